>>> hdl/assert_macros.svh
// Assertion macros shared by the minimum-image distance RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is applied
`define MMID_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MMID_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

>>> hdl/mmid_pkg.sv
// Types and constants for the minimum-image distance pipeline.
// No dependencies; imported by the cells and the top level.
package mmid_pkg;
	localparam int LANES      = 3;
	localparam int CELL_W     = 31;
	localparam int WRAP_W     = 30;
	localparam int SQ_W       = 2 * WRAP_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int SQRT_STEPS = SUM_W / 2;
	localparam int OUT_W      = 32;

	typedef logic [CELL_W-1:0] cell_len_t;
	typedef logic [SUM_W-1:0]  sum_t;

	localparam cell_len_t CELL_RESET = 31'd65536;
endpackage

>>> hdl/mmid_mod_cell.sv
// One restoring-division step of the per-axis remainder, all three axes.
// Depends on mmid_pkg.
module mmid_mod_cell #(
	parameter int MAG_W = 33
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  en,
	input  mmid_pkg::cell_len_t                                   cell_length,
	input  logic                                                  valid_in,
	input  logic [mmid_pkg::LANES-1:0][mmid_pkg::CELL_W-1:0]      rem_in,
	input  logic [mmid_pkg::LANES-1:0][MAG_W-1:0]                 mag_in,
	output logic                                                  valid_out,
	output logic [mmid_pkg::LANES-1:0][mmid_pkg::CELL_W-1:0]      rem_out,
	output logic [mmid_pkg::LANES-1:0][MAG_W-1:0]                 mag_out
);
	import mmid_pkg::*;

	logic [LANES-1:0][CELL_W-1:0] rem_n;
	logic [LANES-1:0][MAG_W-1:0]  mag_n;
	logic                         valid_s1;
	logic [LANES-1:0][CELL_W-1:0] rem_s1;
	logic [LANES-1:0][MAG_W-1:0]  mag_s1;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic [CELL_W:0] trial;
			trial = {rem_in[l], mag_in[l][MAG_W-1]};
			if (trial >= {1'b0, cell_length}) begin
				rem_n[l] = CELL_W'(trial - {1'b0, cell_length});
			end else begin
				rem_n[l] = trial[CELL_W-1:0];
			end
			mag_n[l] = {mag_in[l][MAG_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= rem_n;
			mag_s1 <= mag_n;
		end
	end

	assign valid_out = valid_s1;
	assign rem_out   = rem_s1;
	assign mag_out   = mag_s1;
endmodule

>>> hdl/mmid_sqrt_cell.sv
// One digit-by-digit step of the integer square root.
// Depends on mmid_pkg.
module mmid_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_in,
	input  mmid_pkg::sum_t rad_in,
	input  mmid_pkg::sum_t res_in,
	output logic           valid_out,
	output mmid_pkg::sum_t rad_out,
	output mmid_pkg::sum_t res_out
);
	import mmid_pkg::*;

	localparam sum_t BIT = sum_t'(1) << (2 * STEP);

	sum_t trial;
	sum_t rad_n;
	sum_t res_n;
	logic valid_s1;
	sum_t rad_s1;
	sum_t res_s1;

	always_comb begin
		trial = res_in + BIT;
		if (rad_in >= trial) begin
			rad_n = rad_in - trial;
			res_n = (res_in >> 1) + BIT;
		end else begin
			rad_n = rad_in;
			res_n = res_in >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= rad_n;
			res_s1 <= res_n;
		end
	end

	assign valid_out = valid_s1;
	assign rad_out   = rad_s1;
	assign res_out   = res_s1;
endmodule

>>> hdl/periodic_min_image_distance_core.sv
// Minimum-image distance core: one pair per cycle while the result side does not stall;
// one magnitude stage, one remainder cell per magnitude bit, wrap, square and sum
// stages, then 31 square-root cells.
// A stall on the result side holds the whole cell chain in place.
// Asynchronous active-low reset empties the chain and sets cell_length to 1.0.
module periodic_min_image_distance_core #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cell_length_wr_en,
	input  logic [mmid_pkg::CELL_W-1:0]                 cell_length_wr_data,
	input  logic                                        s_axis_tvalid,
	output logic                                        s_axis_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z, zero fill
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
	output logic                                        m_axis_tvalid,
	input  logic                                        m_axis_tready,
	// pair_distance
	output logic [mmid_pkg::OUT_W-1:0]                  m_axis_tdata
);
	import mmid_pkg::*;
	`include "assert_macros.svh"

	localparam int MAG_W = COORD_WIDTH + 1;

	logic      en;
	cell_len_t cell_length_q;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_length_q <= CELL_RESET;
		end else if (cell_length_wr_en && cell_length_wr_data != '0) begin
			cell_length_q <= cell_length_wr_data;
		end
	end

	// axis magnitudes
	logic [LANES-1:0][MAG_W-1:0] mag_n;
	logic [LANES-1:0][MAG_W-1:0] mag_s1;
	logic                        valid_s1;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic [MAG_W-1:0] diff;
			diff = {s_axis_tdata[l*COORD_WIDTH+COORD_WIDTH-1], s_axis_tdata[l*COORD_WIDTH +: COORD_WIDTH]}
				- {s_axis_tdata[(l+3)*COORD_WIDTH+COORD_WIDTH-1],
				s_axis_tdata[(l+3)*COORD_WIDTH +: COORD_WIDTH]};
			mag_n[l] = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_n;
		end
	end

	// remainder chain, one magnitude bit per cell
	logic [MAG_W:0]                            mv;
	logic [MAG_W:0][LANES-1:0][CELL_W-1:0]     mrem;
	logic [MAG_W:0][LANES-1:0][MAG_W-1:0]      mmag;

	assign mv[0]   = valid_s1;
	assign mrem[0] = '0;
	assign mmag[0] = mag_s1;

	for (genvar i = 0; i < MAG_W; i++) begin : g_mod
		mmid_mod_cell #(.MAG_W(MAG_W)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.cell_length(cell_length_q),
			.valid_in   (mv[i]),
			.rem_in     (mrem[i]),
			.mag_in     (mmag[i]),
			.valid_out  (mv[i+1]),
			.rem_out    (mrem[i+1]),
			.mag_out    (mmag[i+1])
		);
	end

	// wrap, square, sum
	logic [LANES-1:0][WRAP_W-1:0] wrap_n;
	logic [LANES-1:0][WRAP_W-1:0] wrap_s2;
	logic [LANES-1:0][SQ_W-1:0]   sq_s3;
	sum_t                         sum_s4;
	logic                         valid_s2, valid_s3, valid_s4;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic [CELL_W-1:0] r;
			r = mrem[MAG_W][l];
			if ({r, 1'b0} >= {1'b0, cell_length_q}) begin
				wrap_n[l] = WRAP_W'(cell_length_q - r);
			end else begin
				wrap_n[l] = r[WRAP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s2 <= mv[MAG_W];
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wrap_s2 <= wrap_n;
			for (int l = 0; l < LANES; l++) begin
				sq_s3[l] <= wrap_s2[l] * wrap_s2[l];
			end
			sum_s4 <= SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
		end
	end

	// square-root chain, one result bit per cell
	logic [SQRT_STEPS:0] sv;
	sum_t                srad [SQRT_STEPS+1];
	sum_t                sres [SQRT_STEPS+1];

	assign sv[0]   = valid_s4;
	assign srad[0] = sum_s4;
	assign sres[0] = '0;

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		mmid_sqrt_cell #(.STEP(SQRT_STEPS - 1 - i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (sv[i]),
			.rad_in   (srad[i]),
			.res_in   (sres[i]),
			.valid_out(sv[i+1]),
			.rad_out  (srad[i+1]),
			.res_out  (sres[i+1])
		);
	end

	// saturate the root to the output width
	assign m_axis_tvalid = sv[SQRT_STEPS];
	assign m_axis_tdata  = (sres[SQRT_STEPS] > sum_t'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
		: sres[SQRT_STEPS][OUT_W-1:0];

	`MMID_ASSERT_ALWAYS(a_cell_nonzero, clk, !arst_n || cell_length_q != '0, "cell length register is zero")
	`MMID_ASSERT(a_wrap_half, clk, arst_n, valid_s2 |-> ({1'b0, wrap_s2[0], 1'b0} <= {2'b0, cell_length_q}) && ({1'b0, wrap_s2[1], 1'b0} <= {2'b0, cell_length_q}) && ({1'b0, wrap_s2[2], 1'b0} <= {2'b0, cell_length_q}), "wrapped component exceeds half a cell")
	`MMID_ASSERT(a_stall_hold, clk, arst_n, !en |=> $stable(sv) && $stable(valid_s4), "chain advanced during a stall")
endmodule

>>> dv/periodic_min_image_distance_core_tb.sv
// Testbench for periodic_min_image_distance_core: drives coordinate pairs over the input
// stream, predicts each wrapped distance in its own model and checks the result stream.
// Depends on mmid_pkg and the core RTL.
module periodic_min_image_distance_core_tb;
	import mmid_pkg::*;

	localparam int CW      = 32;
	localparam int DATA_W  = ((6*CW+7)/8)*8;
	localparam int LAT     = CW + 36;
	localparam int N_RAND  = 1250;

	logic              clk;
	logic              arst_n;
	logic              cell_length_wr_en;
	cell_len_t         cell_length_wr_data;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;

	logic [DATA_W-1:0] pair_queue[$];
	logic [OUT_W-1:0]  dist_expected[$];
	cell_len_t         cell_model;
	int                mismatches = 0;
	int                results_seen = 0;
	int                pairs_sent = 0;
	int                configs_done = 0;
	bit                s_fire = 1'b0;
	bit                no_idle;
	bit                hold_done = 1'b0;
	int                hold_cnt = 0;

	periodic_min_image_distance_core #(.COORD_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n),
		.cell_length_wr_en(cell_length_wr_en), .cell_length_wr_data(cell_length_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// wrapped magnitude of one axis under the current cell length
	function automatic longint unsigned wrap_axis(logic [CW-1:0] a, logic [CW-1:0] b);
		longint sa, sb;
		longint unsigned mag, r, len;
		sa = longint'($signed(a));
		sb = longint'($signed(b));
		len = longint'(cell_model);
		mag = (sa >= sb) ? longint'(sa - sb) : longint'(sb - sa);
		r = mag % len;
		return (2 * r >= len) ? len - r : r;
	endfunction

	function automatic logic [OUT_W-1:0] pair_distance(logic [DATA_W-1:0] d);
		longint unsigned sum, w, res, bit_v;
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			w = wrap_axis(d[k*CW +: CW], d[(k+3)*CW +: CW]);
			sum += w * w;
		end
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > sum) bit_v >>= 2;
		while (bit_v != 0) begin
			if (sum >= res + bit_v) begin
				sum -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
		return res[OUT_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] pack_pair(logic [CW-1:0] ax, ay, az, bx, by, bz);
		logic [DATA_W-1:0] d;
		d = '0;
		d[0*CW +: CW] = ax;
		d[1*CW +: CW] = ay;
		d[2*CW +: CW] = az;
		d[3*CW +: CW] = bx;
		d[4*CW +: CW] = by;
		d[5*CW +: CW] = bz;
		return d;
	endfunction

	// append one pair to the pending queue
	task automatic enqueue_pair(logic [DATA_W-1:0] d);
		pair_queue = {pair_queue, d};
	endtask

	task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// sample transfers at the rising edge
	always @(posedge clk) begin
		s_fire <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			dist_expected = {dist_expected, pair_distance(s_axis_tdata)};
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (dist_expected.size() == 0)
				report_mismatch("unexpected result", m_axis_tdata, '0);
			else if (m_axis_tdata !== dist_expected[0])
				report_mismatch("pair_distance", m_axis_tdata, dist_expected.pop_front());
			else
				void'(dist_expected.pop_front());
		end
	end

	// driver: advance to the next pair after each transfer, idle at random unless no_idle is set
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_fire || !s_axis_tvalid) begin
			if (pair_queue.size() != 0 && (no_idle || $urandom_range(99) >= 37)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= pair_queue.pop_front();
				pairs_sent++;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor side: random stall unless no_idle is set, plus one long hold-off to back up the pipeline
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			m_axis_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (!hold_done && results_seen >= 200) begin
			m_axis_tready <= 1'b0;
			hold_cnt <= 400;
			hold_done <= 1'b1;
		end else begin
			m_axis_tready <= no_idle || ($urandom_range(99) >= 37);
		end
	end

	task automatic write_cell(cell_len_t v);
		@(negedge clk);
		cell_length_wr_en   = 1'b1;
		cell_length_wr_data = v;
		if (v != 0) cell_model = v;
		configs_done++;
		@(negedge clk);
		cell_length_wr_en = 1'b0;
	endtask

	task automatic drain();
		while (pair_queue.size() != 0 || s_axis_tvalid || dist_expected.size() != 0)
			@(negedge clk);
		repeat (LAT + 10) @(negedge clk);
	endtask

	task automatic add_random_pairs(int n);
		logic [CW-1:0] a[3], b[3];
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 3; k++) begin
				a[k] = $urandom;
				if ($urandom_range(9) < 6)
					b[k] = $urandom;
				else  // a multiple of the cell plus up to about half a cell: exercises the rounding edge
					b[k] = a[k] + $urandom_range(7) * cell_model
					       + $urandom_range(cell_model / 2 + 2) - 1;
			end
			enqueue_pair(pack_pair(a[0], a[1], a[2], b[0], b[1], b[2]));
		end
	endtask

	task automatic add_directed_pairs();
		logic [CW-1:0] half;
		half = cell_model / 2;
		enqueue_pair(pack_pair(0, 0, 0, 0, 0, 0));
		enqueue_pair(pack_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		enqueue_pair(pack_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
		enqueue_pair(pack_pair(half, half, half, 0, 0, 0));
		enqueue_pair(pack_pair(half - 1, half + 1, 0, 0, 0, half));
		enqueue_pair(pack_pair(cell_model, 0, 0 - cell_model, 0, cell_model, 0));
		enqueue_pair(pack_pair(3 * cell_model + half, 0, 0, 0, 0, 0));
		enqueue_pair(pack_pair(0 - half, 7, 32'h8000_0000, 0, 32'hFFFF_FFF9,
			32'h8000_0000));
	endtask

	initial begin
		arst_n = 1'b0;
		cell_length_wr_en = 1'b0;
		cell_length_wr_data = '0;
		cell_model = CELL_RESET;
		no_idle = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset cell length first, then a range of written values
		add_directed_pairs();
		add_random_pairs(250);
		drain();
		write_cell(31'd1);
		add_directed_pairs();
		add_random_pairs(100);
		drain();
		write_cell(31'h7FFF_FFFF);
		add_directed_pairs();
		add_random_pairs(150);
		drain();
		write_cell(31'd0);  // ignored: cell length holds
		add_random_pairs(100);
		drain();
		write_cell(31'd3 * 31'd65536 + 31'd5);
		no_idle = 1;
		add_random_pairs(300);
		drain();
		no_idle = 0;
		for (int p = 0; p < 5; p++) begin
			write_cell(cell_len_t'($urandom_range(32'h7FFF_FFFF, 1)));
			add_random_pairs(70);
			drain();
		end
		write_cell(31'd65536);
		add_random_pairs(50);
		drain();

		$display("Covered %0d pairs and %0d results over %0d cell length writes,",
			pairs_sent, results_seen, configs_done);
		$display("including a zero write, both cell extremes and a long output hold-off.");
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("Timeout with %0d results outstanding", dist_expected.size());
		$display("Simulation FAILED");
		$finish;
	end
endmodule
